FILE: rtl/vadpcm_pkg.sv
// Shared types, constants and arithmetic helpers for the VADPCM frame decoder.
package vadpcm_pkg;

    localparam int LANES       = 8;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = 36;
    localparam int FRAC_BITS   = 11;
    localparam int NIB_W       = 4;
    localparam int COEF_ADDR_W = 7;
    localparam int BANK_SEL_W  = 4;
    localparam int PAGE_SEL_N  = 16;
    localparam int MODE_W      = 2;
    localparam int CMD_W       = 2;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = LANES * SAMPLE_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SAMPLE_W;

    // start mode bits
    localparam int MODE_ZERO_BIT = 0;
    localparam int MODE_LOOP_BIT = 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LANES-1:0][SAMPLE_W-1:0] group_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_DECODE    = 2'd1,
        CMD_SET_HIST  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic load2;
        logic load3;
        logic load4;
    } lane_ctl_t;

    typedef struct packed {
        group_t samples;
        logic   last;
    } out_item_t;

    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] v);
        sample_t r;
        if (v > ACC_W'(SAMPLE_MAX))
            r = SAMPLE_MAX;
        else if (v < ACC_W'(SAMPLE_MIN))
            r = SAMPLE_MIN;
        else
            r = sample_t'(v);
        return r;
    endfunction

    // signed nibble times 2^shift, clamped to 16 bits
    function automatic sample_t scale_nibble(input logic [NIB_W-1:0] nib,
                                             input logic [NIB_W-1:0] shift);
        logic signed [ACC_W-1:0] wide;
        wide = ACC_W'($signed(nib)) <<< shift;
        return sat_sample(wide);
    endfunction

endpackage

FILE: rtl/vadpcm_codebook.sv
// Codebook store: one bank per row word, read a whole page per decode.
module vadpcm_codebook #(
    parameter int NUM_PAGES = 8,
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [vadpcm_pkg::COEF_ADDR_W-1:0]   wr_addr,
    input  vadpcm_pkg::sample_t                  wr_data,
    input  logic                                 rd_en,
    input  logic [PAGE_W-1:0]                    rd_page,
    output vadpcm_pkg::group_t                   c0_row,
    output vadpcm_pkg::group_t                   c1_row
);
    import vadpcm_pkg::*;

    localparam int BANKS = 2 * LANES;

    logic [COEF_ADDR_W-BANK_SEL_W-1:0] wr_page;
    logic                              wr_ok;
    logic [PAGE_W-1:0]                 wr_idx;

    assign wr_page = wr_addr[COEF_ADDR_W-1:BANK_SEL_W];
    // drop writes beyond the last page
    assign wr_ok   = 32'(wr_page) < NUM_PAGES;
    assign wr_idx  = PAGE_W'(wr_page);

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        sample_t mem [NUM_PAGES];
        sample_t rd_q_reg;
        logic    bank_we;

        assign bank_we = wr_en && wr_ok && (wr_addr[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

        always_ff @(posedge clk)
        begin
            if (bank_we)
                mem[wr_idx] <= wr_data;
            if (rd_en)
                rd_q_reg <= mem[rd_page];
        end

        if (b < LANES) begin : g_row0
            assign c0_row[b] = rd_q_reg;
        end else begin : g_row1
            assign c1_row[b-LANES] = rd_q_reg;
        end
    end

endmodule

FILE: rtl/vadpcm_lane.sv
// One prediction lane: innovation products, partial sums and history term.
module vadpcm_lane #(
    parameter int LANE = 0
) (
    input  logic                   clk,
    input  vadpcm_pkg::lane_ctl_t  ctl,
    input  vadpcm_pkg::group_t     inv,
    input  vadpcm_pkg::sample_t    c0,
    input  vadpcm_pkg::group_t     c1_row,
    input  vadpcm_pkg::sample_t    older,
    input  vadpcm_pkg::sample_t    newer,
    output vadpcm_pkg::sample_t    res
);
    import vadpcm_pkg::*;

    localparam int HALF = LANES / 2;

    logic signed [ACC_W-1:0]  term [LANES];
    sample_t                  inv_reg;
    sample_t                  c0_s2_reg, c0_s3_reg, c0_s4_reg;
    sample_t                  c1_s2_reg, c1_s3_reg, c1_s4_reg;
    logic signed [ACC_W-1:0]  sum_lo_next, sum_hi_next;
    logic signed [ACC_W-1:0]  sum_lo_reg, sum_hi_reg;
    logic signed [ACC_W-1:0]  pre_reg;
    logic signed [PROD_W-1:0] p_older, p_newer;
    logic signed [ACC_W-1:0]  acc;

    // earlier innovations of the group through the newer codebook row
    for (genvar k = 0; k < LANES - 1; k++) begin : g_tap
        if (k < LANE) begin : g_mul
            logic signed [PROD_W-1:0] prod_reg;
            always_ff @(posedge clk)
            begin
                if (ctl.load2)
                    prod_reg <= $signed(c1_row[LANE-k-1]) * $signed(inv[k]);
            end
            assign term[k] = ACC_W'(prod_reg);
        end else begin : g_zero
            assign term[k] = '0;
        end
    end

    assign term[LANES-1] = ACC_W'(inv_reg) <<< FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (ctl.load2)
        begin
            inv_reg   <= inv[LANE];
            c0_s2_reg <= c0;
            c1_s2_reg <= c1_row[LANE];
        end
        if (ctl.load3)
        begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
            c0_s3_reg  <= c0_s2_reg;
            c1_s3_reg  <= c1_s2_reg;
        end
        if (ctl.load4)
        begin
            pre_reg   <= sum_lo_reg + sum_hi_reg;
            c0_s4_reg <= c0_s3_reg;
            c1_s4_reg <= c1_s3_reg;
        end
    end

    always_comb
    begin
        sum_lo_next = '0;
        sum_hi_next = '0;
        for (int i = 0; i < HALF; i++)
        begin
            sum_lo_next = sum_lo_next + term[i];
            sum_hi_next = sum_hi_next + term[HALF+i];
        end
    end

    // history term closes the group-to-group loop
    assign p_older = c0_s4_reg * older;
    assign p_newer = c1_s4_reg * newer;
    assign acc     = ACC_W'(p_older) + ACC_W'(p_newer) + pre_reg;
    assign res     = sat_sample(acc >>> FRAC_BITS);

endmodule

FILE: rtl/vadpcm_outbuf.sv
// Two-entry output buffer: output register plus skid register.
module vadpcm_outbuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vadpcm_pkg::out_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vadpcm_pkg::out_item_t  out_item
);
    import vadpcm_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_item_reg, skid_item_reg;
    logic      in_fire, out_fire, out_free;
    logic      load_from_skid, load_from_in, load_skid;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_free = out_fire || !out_valid_reg;

    assign load_from_skid = out_free && skid_valid_reg;
    assign load_from_in   = out_free && !skid_valid_reg && in_fire;
    assign load_skid      = !out_free && in_fire;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
            out_item_reg <= skid_item_reg;
        else if (load_from_in)
            out_item_reg <= in_item;
        if (load_skid)
            skid_item_reg <= in_item;
    end

endmodule

FILE: rtl/vadpcm_frame_decoder.sv
// VADPCM frame decoder top: front register, eight prediction lanes, merge and output buffer.
// Path: each group of a frame passes the front register, the lane load2, load3 and load4 registers
// and the output register to m_tvalid, the second group behind the first; set-history and
// codebook loads give no result. Throughput: one group per cycle through the lanes while
// m_tready does not stall them; a frame issues two groups and the next item is taken as its second issues.
// Reset: rst_n asynchronous, clears history, loop registers and all valid flags; codebook is not cleared.
module vadpcm_frame_decoder #(
    parameter int NUM_PAGES = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // coef_index[6:0] coef_value[22:7] header[30:23] frame_data[94:31]
    // start_mode[96:95] hist_older[112:97] hist_newer[128:113], zero fill above
    input  logic [vadpcm_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd[1:0]
    input  logic [vadpcm_pkg::CMD_W-1:0]          s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sample_0[15:0] sample_1[31:16] ... sample_7[127:112]
    output logic [vadpcm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [vadpcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vadpcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vadpcm_pkg::*;

    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_OLDER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_NEWER = 1'b1;

    typedef struct packed {
        logic              is_hist;
        logic              last;
        logic [MODE_W-1:0] mode;
        sample_t           h_older;
        sample_t           h_newer;
    } tok_t;

    // input fields
    cmd_t                   in_cmd;
    logic [COEF_ADDR_W-1:0] in_coef_index;
    sample_t                in_coef_value;
    logic [NIB_W-1:0]       in_shift;
    logic [NIB_W-1:0]       in_page_sel;
    logic [63:0]            in_frame;
    logic [MODE_W-1:0]      in_mode;
    sample_t                in_hist_older, in_hist_newer;
    group_t                 in_inv0, in_inv1;

    assign in_cmd        = cmd_t'(s_tuser);
    assign in_coef_index = s_tdata[6:0];
    assign in_coef_value = s_tdata[22:7];
    assign in_page_sel   = s_tdata[26:23];
    assign in_shift      = s_tdata[30:27];
    assign in_frame      = s_tdata[94:31];
    assign in_mode       = s_tdata[96:95];
    assign in_hist_older = s_tdata[112:97];
    assign in_hist_newer = s_tdata[128:113];

    // innovations, high nibble first
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            in_inv0[k] = scale_nibble(in_frame[63-NIB_W*k -: NIB_W], in_shift);
            in_inv1[k] = scale_nibble(in_frame[31-NIB_W*k -: NIB_W], in_shift);
        end
    end

    // page select wraps modulo the page count
    logic [PAGE_W-1:0] page_map [PAGE_SEL_N];
    for (genvar v = 0; v < PAGE_SEL_N; v++) begin : g_page_map
        assign page_map[v] = PAGE_W'(v % NUM_PAGES);
    end

    logic accept, load_frame, load_hist, load_front;
    logic issue, front_last;
    logic ready2, ready3, ready4, r5;
    logic load3, load4, fire5;

    assign accept     = s_tvalid && s_tready;
    assign load_frame = accept && (in_cmd == CMD_DECODE);
    assign load_hist  = accept && (in_cmd == CMD_SET_HIST);
    assign load_front = load_frame || load_hist;

    // front register: a frame issues two groups, a set-history one token
    logic              front_valid_reg, front_valid_next;
    logic              front_phase_reg, front_phase_next;
    logic              front_hist_reg;
    logic [MODE_W-1:0] front_mode_reg;
    group_t            inv0_reg, inv1_reg;
    sample_t           front_older_reg, front_newer_reg;

    assign front_last = front_hist_reg || front_phase_reg;
    assign issue      = front_valid_reg && ready2;
    assign s_tready   = !front_valid_reg || (issue && front_last);

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_phase_next = front_phase_reg;
        if (load_front)
        begin
            front_valid_next = 1'b1;
            front_phase_next = 1'b0;
        end
        else if (issue)
        begin
            front_valid_next = !front_last;
            front_phase_next = !front_phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            front_phase_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
            front_phase_reg <= front_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_front)
        begin
            front_hist_reg  <= load_hist;
            front_mode_reg  <= in_mode;
            inv0_reg        <= in_inv0;
            inv1_reg        <= in_inv1;
            front_older_reg <= in_hist_older;
            front_newer_reg <= in_hist_newer;
        end
    end

    // codebook
    group_t cb_c0, cb_c1;

    vadpcm_codebook #(
        .NUM_PAGES (NUM_PAGES)
    ) u_codebook (
        .clk     (clk),
        .wr_en   (accept && (in_cmd == CMD_LOAD_COEF)),
        .wr_addr (in_coef_index),
        .wr_data (in_coef_value),
        .rd_en   (load_frame),
        .rd_page (page_map[in_page_sel]),
        .c0_row  (cb_c0),
        .c1_row  (cb_c1)
    );

    // token pipeline alongside the lanes
    logic   v2_reg, v3_reg, v4_reg;
    tok_t   tok_issue, tok2_reg, tok3_reg, tok4_reg;
    group_t issue_inv;

    assign issue_inv = front_phase_reg ? inv1_reg : inv0_reg;

    always_comb
    begin
        tok_issue.is_hist = front_hist_reg;
        tok_issue.last    = front_phase_reg;
        tok_issue.mode    = front_mode_reg;
        tok_issue.h_older = front_older_reg;
        tok_issue.h_newer = front_newer_reg;
    end

    logic ob_in_ready;

    // hist tokens leave at the merge stage without an output slot
    assign r5     = tok4_reg.is_hist || ob_in_ready;
    assign ready4 = !v4_reg || r5;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign load3  = v2_reg && ready3;
    assign load4  = v3_reg && ready4;
    assign fire5  = v4_reg && r5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= issue || (v2_reg && !load3);
            v3_reg <= load3 || (v3_reg && !load4);
            v4_reg <= load4 || (v4_reg && !fire5);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            tok2_reg <= tok_issue;
        if (load3)
            tok3_reg <= tok2_reg;
        if (load4)
            tok4_reg <= tok3_reg;
    end

    // history and loop registers
    sample_t hist_older_reg, hist_newer_reg;
    sample_t loop_older_reg, loop_newer_reg;
    sample_t sel_older, sel_newer;
    group_t  lane_res;

    always_comb
    begin
        if (!tok4_reg.last && tok4_reg.mode[MODE_ZERO_BIT])
        begin
            sel_older = '0;
            sel_newer = '0;
        end
        else if (!tok4_reg.last && tok4_reg.mode[MODE_LOOP_BIT])
        begin
            sel_older = loop_older_reg;
            sel_newer = loop_newer_reg;
        end
        else
        begin
            sel_older = hist_older_reg;
            sel_newer = hist_newer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_older_reg <= '0;
            hist_newer_reg <= '0;
            loop_older_reg <= '0;
            loop_newer_reg <= '0;
        end
        else
        begin
            if (fire5)
            begin
                if (tok4_reg.is_hist)
                begin
                    hist_older_reg <= tok4_reg.h_older;
                    hist_newer_reg <= tok4_reg.h_newer;
                end
                else
                begin
                    hist_older_reg <= lane_res[LANES-2];
                    hist_newer_reg <= lane_res[LANES-1];
                end
            end
            if (cfg_we && (cfg_index == REG_LOOP_OLDER))
                loop_older_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_LOOP_NEWER))
                loop_newer_reg <= cfg_data;
        end
    end

    // lanes
    lane_ctl_t lane_ctl;

    always_comb
    begin
        lane_ctl.load2 = issue;
        lane_ctl.load3 = load3;
        lane_ctl.load4 = load4;
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        vadpcm_lane #(
            .LANE (j)
        ) u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .inv    (issue_inv),
            .c0     (cb_c0[j]),
            .c1_row (cb_c1),
            .older  (sel_older),
            .newer  (sel_newer),
            .res    (lane_res[j])
        );
    end

    // merge lane results into one item
    out_item_t ob_in_item, ob_out_item;

    always_comb
    begin
        ob_in_item.samples = lane_res;
        ob_in_item.last    = tok4_reg.last;
    end

    vadpcm_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg && !tok4_reg.is_hist),
        .in_ready  (ob_in_ready),
        .in_item   (ob_in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (ob_out_item)
    );

    assign m_tdata = ob_out_item.samples;
    assign m_tlast = ob_out_item.last;

endmodule
